// ===== rtl/core/timecode_frame_converter_unit_defines.svh =====
// Assertion macros used by the timecode converter checker.
`ifndef TIMECODE_FRAME_CONVERTER_UNIT_DEFINES_SVH
`define TIMECODE_FRAME_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tcfc_pkg.sv =====
// Shared types, constants and helper functions of the timecode converter.
package tcfc_pkg;

  // Field widths
  localparam int unsigned FrameNumW  = 22;
  localparam int unsigned TimecodeW  = 32;
  localparam int unsigned FramesOutW = 26;
  localparam int unsigned HoursW     = 5;
  localparam int unsigned FieldW     = 6;
  localparam int unsigned RateW      = 6;
  localparam int unsigned ByteW      = 8;

  // Stream packing
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutUsedW = FramesOutW + HoursW + 3 * FieldW;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned OutPadW  = OutDataW - OutUsedW;

  // Pipeline depth, shared by both datapaths
  localparam int unsigned NumStages = 11;

  // Rate register
  localparam logic [RateW-1:0] RateReset = 6'd30;
  localparam logic [RateW-1:0] DropFps   = 6'd30;

  // Direction of a request
  typedef enum logic {
    ModeToFrames   = 1'b0,
    ModeToTimecode = 1'b1
  } mode_e;

  // Time units
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned MinsPerHour = 60;
  localparam int unsigned HoursPerDay = 24;

  // Drop-frame constants
  localparam logic [FrameNumW-1:0] DayFrames = 22'd2589408;
  localparam int unsigned TenMinFrames = 17982;
  localparam int unsigned MinFrames    = 1798;
  localparam int unsigned TenMinAdd    = 18;
  localparam int unsigned MinSkip      = 2;
  localparam int unsigned DropPerHour  = 108;

  // Reciprocals: ceil(2^k / d) with k = numerator bits + ceil(log2 d), exact floor
  localparam int unsigned TenMinShift = 37;
  localparam int unsigned TenMinRecipW = 23;
  localparam logic [TenMinRecipW-1:0] TenMinRecip = TenMinRecipW'(
      ((64'd1 << TenMinShift) + 64'(TenMinFrames) - 64'd1) / 64'(TenMinFrames));

  localparam int unsigned MinShift = 26;
  localparam int unsigned MinRecipW = 16;
  localparam logic [MinRecipW-1:0] MinRecip = MinRecipW'(
      ((64'd1 << MinShift) + 64'(MinFrames) - 64'd1) / 64'(MinFrames));

  localparam int unsigned SecShift = 28;
  localparam int unsigned SecRecipW = 23;
  localparam logic [SecRecipW-1:0] SecRecip = SecRecipW'(
      ((64'd1 << SecShift) + 64'(SecsPerMin) - 64'd1) / 64'(SecsPerMin));

  localparam int unsigned HourShift = 34;
  localparam int unsigned HourRecipW = 23;
  localparam int unsigned SecsPerHour = SecsPerMin * MinsPerHour;
  localparam logic [HourRecipW-1:0] HourRecip = HourRecipW'(
      ((64'd1 << HourShift) + 64'(SecsPerHour) - 64'd1) / 64'(SecsPerHour));

  localparam int unsigned DayShift = 16;
  localparam int unsigned DayRecipW = 12;
  localparam logic [DayRecipW-1:0] DayRecip = DayRecipW'(
      ((64'd1 << DayShift) + 64'(HoursPerDay) - 64'd1) / 64'(HoursPerDay));

  localparam int unsigned TenthShift = 12;
  localparam int unsigned TenthRecipW = 9;
  localparam logic [TenthRecipW-1:0] TenthRecip = TenthRecipW'(
      ((64'd1 << TenthShift) + 64'd9) / 64'd10);

  // Divider chunk: quotient bits retired per pipeline stage
  localparam int unsigned DivChunkW = 8;

  // Timebase seen by the datapaths
  typedef struct packed {
    logic             drop;
    logic [RateW-1:0] fps;
  } rate_cfg_t;

  // Restoring division over one chunk of numerator bits; returns {remainder, quotient}
  function automatic logic [RateW+DivChunkW-1:0] div_chunk(
      input logic [RateW-1:0]     rem,
      input logic [DivChunkW-1:0] bits,
      input logic [RateW-1:0]     den);
    logic [RateW:0]     r;
    logic [DivChunkW-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = DivChunkW - 1; i >= 0; i--) begin
      r = {r[RateW-1:0], bits[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return {r[RateW-1:0], q};
  endfunction

endpackage

// ===== rtl/core/tcfc_dec.sv =====
// Timecode to frame count datapath, pipelined to the common depth.
module tcfc_dec (
  input  logic                                 clk_i,
  input  logic                                 adv_i,
  input  logic                                 mode_i,
  input  tcfc_pkg::rate_cfg_t                  cfg_i,
  input  logic [tcfc_pkg::TimecodeW-1:0]       tc_i,
  output logic [tcfc_pkg::FramesOutW-1:0]      frames_o
);

  localparam int unsigned ByteW    = tcfc_pkg::ByteW;
  localparam int unsigned FrW      = tcfc_pkg::FramesOutW;
  localparam int unsigned DelayLen = tcfc_pkg::NumStages - 4;

  // Mode of the items in the first four stages
  logic [3:0] mode_q;

  // Stage 0: split the timecode bytes
  logic [ByteW-1:0] hrs0_q, min0_q, sec0_q, frm0_q;
  logic drop0_q;
  logic [tcfc_pkg::RateW-1:0] fps0_q;

  // Stage 1: hours and minutes folded, drop correction
  logic [13:0] hm1_d, hm1_q;
  logic [15:0] corr1_d, corr1_q;
  logic [16:0] tenth_prod;
  logic [ByteW-1:0] tenths;
  logic [ByteW-1:0] sec1_q, frm1_q;
  logic drop1_q;
  logic [tcfc_pkg::RateW-1:0] fps1_q;

  // Stage 2: total seconds
  logic [19:0] hms2_d, hms2_q;
  logic [ByteW-1:0] frm2_q;
  logic [15:0] corr2_q;
  logic drop2_q;
  logic [tcfc_pkg::RateW-1:0] fps2_q;

  // Stage 3: scaled by the frame rate
  logic [FrW-1:0] prod3_d, prod3_q;
  logic [ByteW-1:0] frm3_q;
  logic [15:0] corr3_q;
  logic drop3_q;

  // Stage 4 onward: result and its delay line
  logic [FrW-1:0] fr4_d;
  logic [FrW-1:0] dly_q [DelayLen];

  always_comb begin
    tenth_prod = 17'(min0_q) * 17'(tcfc_pkg::TenthRecip);
    tenths     = ByteW'(tenth_prod >> tcfc_pkg::TenthShift);
    hm1_d      = 14'(hrs0_q) * 14'(tcfc_pkg::MinsPerHour) + 14'(min0_q);
    corr1_d    = 16'(hrs0_q) * 16'(tcfc_pkg::DropPerHour) + {7'd0, min0_q - tenths, 1'b0};
    hms2_d     = 20'(hm1_q) * 20'(tcfc_pkg::SecsPerMin) + 20'(sec1_q);
    prod3_d    = FrW'(hms2_q) * FrW'(fps2_q);
    // Drop the frame count result for frame-to-timecode requests
    if (mode_q[3] == tcfc_pkg::ModeToTimecode) begin
      fr4_d = '0;
    end else begin
      fr4_d = prod3_q + FrW'(frm3_q) - (drop3_q ? FrW'(corr3_q) : FrW'(0));
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode_q  <= {mode_q[2:0], mode_i};
      hrs0_q  <= tc_i[31:24];
      min0_q  <= tc_i[23:16];
      sec0_q  <= tc_i[15:8];
      frm0_q  <= tc_i[7:0];
      drop0_q <= cfg_i.drop;
      fps0_q  <= cfg_i.fps;

      hm1_q   <= hm1_d;
      corr1_q <= corr1_d;
      sec1_q  <= sec0_q;
      frm1_q  <= frm0_q;
      drop1_q <= drop0_q;
      fps1_q  <= fps0_q;

      hms2_q  <= hms2_d;
      frm2_q  <= frm1_q;
      corr2_q <= corr1_q;
      drop2_q <= drop1_q;
      fps2_q  <= fps1_q;

      prod3_q <= prod3_d;
      frm3_q  <= frm2_q;
      corr3_q <= corr2_q;
      drop3_q <= drop2_q;

      dly_q[0] <= fr4_d;
      for (int i = 1; i < DelayLen; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign frames_o = dly_q[DelayLen-1];

endmodule

// ===== rtl/core/tcfc_enc.sv =====
// Frame count to timecode datapath: drop-frame fold, rate divider, time split.
module tcfc_enc (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic                                mode_i,
  input  tcfc_pkg::rate_cfg_t                 cfg_i,
  input  logic [tcfc_pkg::FrameNumW-1:0]      fnum_i,
  output logic [tcfc_pkg::HoursW-1:0]         hours_o,
  output logic [tcfc_pkg::FieldW-1:0]         minutes_o,
  output logic [tcfc_pkg::FieldW-1:0]         seconds_o,
  output logic [tcfc_pkg::FieldW-1:0]         frames_o
);

  localparam int unsigned NumW = tcfc_pkg::FrameNumW;
  localparam int unsigned RW   = tcfc_pkg::RateW;
  localparam int unsigned FW   = tcfc_pkg::FieldW;
  localparam int unsigned CW   = tcfc_pkg::DivChunkW;
  localparam int unsigned TenProdW  = NumW + tcfc_pkg::TenMinRecipW;
  localparam int unsigned MinProdW  = 15 + tcfc_pkg::MinRecipW;
  localparam int unsigned SecProdW  = NumW + tcfc_pkg::SecRecipW;
  localparam int unsigned HourProdW = NumW + tcfc_pkg::HourRecipW;
  localparam int unsigned DayProdW  = 11 + tcfc_pkg::DayRecipW;

  // Mode of the items in stages 0 to NumStages-2
  logic [tcfc_pkg::NumStages-2:0] mode_q;

  // Stage 0: fold into one day when drop-frame
  logic [NumW-1:0] num0_d, num0_q;
  logic drop0_q;
  logic [RW-1:0] fps0_q;

  // Stage 1: ten-minute block count
  logic [TenProdW-1:0] ten_prod;
  logic [7:0] ten1_d, ten1_q;
  logic [NumW-1:0] num1_q;
  logic drop1_q;
  logic [RW-1:0] fps1_q;

  // Stage 2: remainder in the block
  logic [NumW-1:0] rem_full;
  logic [14:0] rem2_q;
  logic [7:0] ten2_q;
  logic [NumW-1:0] num2_q;
  logic drop2_q;
  logic [RW-1:0] fps2_q;

  // Stage 3: skipped minutes within the block
  logic [MinProdW-1:0] min_prod;
  logic [3:0] min3_d, min3_q;
  logic [7:0] ten3_q;
  logic [NumW-1:0] num3_q;
  logic drop3_q;
  logic [RW-1:0] fps3_q;

  // Stage 4: adjusted frame count
  logic [NumW-1:0] adj4_d, adj4_q;
  logic [RW-1:0] fps4_q;

  // Stages 5 to 7: divide by the frame rate, one byte of quotient each
  logic [RW+CW-1:0] chunk5, chunk6, chunk7;
  logic [RW-1:0] rem5_q, rem6_q;
  logic [CW-1:0] qhi5_q;
  logic [2*CW-1:0] qmid6_q;
  logic [15:0] low5_q;
  logic [7:0] low6_q;
  logic [RW-1:0] fps5_q, fps6_q;
  logic [3*CW-1:0] quo24;
  logic [NumW-1:0] quo7_q;
  logic [FW-1:0] frm7_q;

  // Stage 8: minutes and hours totals
  logic [SecProdW-1:0] mq_prod;
  logic [HourProdW-1:0] hq_prod;
  logic [NumW-1:0] quo8_q;
  logic [16:0] mq8_q;
  logic [10:0] hq8_q;
  logic [FW-1:0] frm8_q;

  // Stage 9: seconds and minutes fields, day count
  logic [NumW-1:0] sec_full;
  logic [16:0] min_full;
  logic [DayProdW-1:0] hd_prod;
  logic [FW-1:0] sec9_q, min9_q, frm9_q;
  logic [10:0] hq9_q;
  logic [5:0] hd9_q;

  // Stage 10: hours field and output
  logic [10:0] hour_full;
  logic [tcfc_pkg::HoursW-1:0] hours_q;
  logic [FW-1:0] minutes_q, seconds_q, frames_q;

  always_comb begin
    num0_d = fnum_i;
    if (cfg_i.drop && (fnum_i >= tcfc_pkg::DayFrames)) begin
      num0_d = fnum_i - tcfc_pkg::DayFrames;
    end

    ten_prod = TenProdW'(num0_q) * TenProdW'(tcfc_pkg::TenMinRecip);
    ten1_d   = 8'(ten_prod >> tcfc_pkg::TenMinShift);

    rem_full = num1_q - NumW'(ten1_q) * NumW'(tcfc_pkg::TenMinFrames);

    min_prod = MinProdW'(rem2_q - 15'(tcfc_pkg::MinSkip)) * MinProdW'(tcfc_pkg::MinRecip);
    min3_d   = (rem2_q >= 15'(tcfc_pkg::MinSkip)) ? 4'(min_prod >> tcfc_pkg::MinShift) : 4'd0;

    // Add back the labels skipped so far
    if (drop3_q) begin
      adj4_d = num3_q + NumW'(ten3_q) * NumW'(tcfc_pkg::TenMinAdd) + NumW'({min3_q, 1'b0});
    end else begin
      adj4_d = num3_q;
    end

    chunk5 = tcfc_pkg::div_chunk('0, {2'b00, adj4_q[21:16]}, fps4_q);
    chunk6 = tcfc_pkg::div_chunk(rem5_q, low5_q[15:8], fps5_q);
    chunk7 = tcfc_pkg::div_chunk(rem6_q, low6_q, fps6_q);
    quo24  = {qmid6_q, chunk7[CW-1:0]};

    mq_prod = SecProdW'(quo7_q) * SecProdW'(tcfc_pkg::SecRecip);
    hq_prod = HourProdW'(quo7_q) * HourProdW'(tcfc_pkg::HourRecip);

    sec_full = quo8_q - NumW'(mq8_q) * NumW'(tcfc_pkg::SecsPerMin);
    min_full = mq8_q - 17'(hq8_q) * 17'(tcfc_pkg::MinsPerHour);
    hd_prod  = DayProdW'(hq8_q) * DayProdW'(tcfc_pkg::DayRecip);

    hour_full = hq9_q - 11'(hd9_q) * 11'(tcfc_pkg::HoursPerDay);
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mode_q <= {mode_q[tcfc_pkg::NumStages-3:0], mode_i};

      num0_q  <= num0_d;
      drop0_q <= cfg_i.drop;
      fps0_q  <= cfg_i.fps;

      num1_q  <= num0_q;
      ten1_q  <= ten1_d;
      drop1_q <= drop0_q;
      fps1_q  <= fps0_q;

      num2_q  <= num1_q;
      ten2_q  <= ten1_q;
      rem2_q  <= rem_full[14:0];
      drop2_q <= drop1_q;
      fps2_q  <= fps1_q;

      num3_q  <= num2_q;
      ten3_q  <= ten2_q;
      min3_q  <= min3_d;
      drop3_q <= drop2_q;
      fps3_q  <= fps2_q;

      adj4_q <= adj4_d;
      fps4_q <= fps3_q;

      rem5_q <= chunk5[RW+CW-1:CW];
      qhi5_q <= chunk5[CW-1:0];
      low5_q <= adj4_q[15:0];
      fps5_q <= fps4_q;

      rem6_q  <= chunk6[RW+CW-1:CW];
      qmid6_q <= {qhi5_q, chunk6[CW-1:0]};
      low6_q  <= low5_q[7:0];
      fps6_q  <= fps5_q;

      frm7_q <= chunk7[RW+CW-1:CW];
      quo7_q <= quo24[NumW-1:0];

      quo8_q <= quo7_q;
      mq8_q  <= 17'(mq_prod >> tcfc_pkg::SecShift);
      hq8_q  <= 11'(hq_prod >> tcfc_pkg::HourShift);
      frm8_q <= frm7_q;

      sec9_q <= sec_full[FW-1:0];
      min9_q <= min_full[FW-1:0];
      hq9_q  <= hq8_q;
      hd9_q  <= 6'(hd_prod >> tcfc_pkg::DayShift);
      frm9_q <= frm8_q;

      // Drop the timecode for timecode-to-frame requests
      if (mode_q[tcfc_pkg::NumStages-2] == tcfc_pkg::ModeToTimecode) begin
        hours_q   <= hour_full[tcfc_pkg::HoursW-1:0];
        minutes_q <= min9_q;
        seconds_q <= sec9_q;
        frames_q  <= frm9_q;
      end else begin
        hours_q   <= '0;
        minutes_q <= '0;
        seconds_q <= '0;
        frames_q  <= '0;
      end
    end
  end

  assign hours_o   = hours_q;
  assign minutes_o = minutes_q;
  assign seconds_o = seconds_q;
  assign frames_o  = frames_q;

endmodule

// ===== rtl/core/timecode_frame_converter_unit.sv =====
// Top level of the SMPTE timecode / frame count converter.
// An accepted request passes through every stage of the pipeline before its result is output.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The rate divider retires one byte of quotient per stage over three stages.
// Reset clears all valid bits and loads 30 fps into the frame rate register.
module timecode_frame_converter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Frame rate register write
  input  logic                            cfg_we_i,
  input  logic [tcfc_pkg::RateW-1:0]      cfg_wdata_i,
  // Request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: frame_number[21:0], timecode_in[53:22], zero pad [55:54]
  input  logic [tcfc_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: mode[0]
  input  logic [0:0]                      s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: frames_out[25:0], out_hours[30:26], out_minutes[36:31],
  //        out_seconds[42:37], out_frames[48:43], zero pad [55:49]
  output logic [tcfc_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned NS = tcfc_pkg::NumStages;

  logic [tcfc_pkg::RateW-1:0] rate_d, rate_q;
  logic [NS-1:0] valid_d, valid_q;
  logic adv;
  tcfc_pkg::rate_cfg_t cfg;

  logic [tcfc_pkg::FramesOutW-1:0] frames_out;
  logic [tcfc_pkg::HoursW-1:0] out_hours;
  logic [tcfc_pkg::FieldW-1:0] out_minutes, out_seconds, out_frames;

  // Hold the frame rate until written
  assign rate_d = cfg_we_i ? cfg_wdata_i : rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= tcfc_pkg::RateReset;
    end else begin
      rate_q <= rate_d;
    end
  end

  // Zero selects 30 fps drop-frame
  always_comb begin
    cfg.drop = (rate_q == '0);
    cfg.fps  = cfg.drop ? tcfc_pkg::DropFps : rate_q;
  end

  // Advance unless the output holds a result not yet taken
  assign adv     = !valid_q[NS-1] || m_axis_tready;
  assign valid_d = {valid_q[NS-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[NS-1];

  tcfc_dec u_dec (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .mode_i   (s_axis_tuser[0]),
    .cfg_i    (cfg),
    .tc_i     (s_axis_tdata[53:22]),
    .frames_o (frames_out)
  );

  tcfc_enc u_enc (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .mode_i    (s_axis_tuser[0]),
    .cfg_i     (cfg),
    .fnum_i    (s_axis_tdata[21:0]),
    .hours_o   (out_hours),
    .minutes_o (out_minutes),
    .seconds_o (out_seconds),
    .frames_o  (out_frames)
  );

  // Pack the result, first field in the lowest bits
  assign m_axis_tdata = {{tcfc_pkg::OutPadW{1'b0}}, out_frames, out_seconds, out_minutes,
                         out_hours, frames_out};

endmodule

// ===== rtl/core/tcfc_checker.sv =====
// Port-level checks of the timecode converter, bound to its top level.
`include "timecode_frame_converter_unit_defines.svh"

module tcfc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [tcfc_pkg::RateW-1:0]      cfg_wdata_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [tcfc_pkg::InDataW-1:0]    s_axis_tdata,
  input logic [0:0]                      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tcfc_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic [tcfc_pkg::FramesOutW-1:0] frames_out;
  logic [tcfc_pkg::HoursW-1:0] hours;
  logic [tcfc_pkg::FieldW-1:0] minutes, seconds, frames;
  logic [tcfc_pkg::OutPadW-1:0] pad;
  logic stall;
  logic tc_in_range;
  logic tc_clear;
  logic one_kind;

  assign {pad, frames, seconds, minutes, hours, frames_out} = m_axis_tdata;
  assign stall = m_axis_tvalid && !m_axis_tready;

  assign tc_in_range = (hours <= 5'd23) && (minutes <= 6'd59) && (seconds <= 6'd59) &&
                       (frames <= 6'd62) && (pad == '0);
  assign tc_clear    = (hours == '0) && (minutes == '0) && (seconds == '0) && (frames == '0);
  assign one_kind    = (frames_out == '0) || tc_clear;

  // Timecode fields stay in their ranges and the pad stays clear
  `TCFC_ASSERT_IMPL(a_tc_range, m_axis_tvalid, tc_in_range, "timecode field out of range")

  // A result carries either a frame count or a timecode, never both
  `TCFC_ASSERT_IMPL(a_one_kind, m_axis_tvalid, one_kind, "frame count and timecode both set")

  // A stalled output blocks new requests
  `TCFC_ASSERT_IMPL(a_backpressure, stall, !s_axis_tready, "request taken while output stalled")

  // A stalled result stays put
  `TCFC_ASSERT_NEXT(a_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind timecode_frame_converter_unit tcfc_checker u_tcfc_checker (.*);
